// ----- rtl/core/sdpa_pkg.sv -----
// ----------------------------------------------------------------------------
// sdpa_pkg
// Shared types and constants for the subset DP minimum-cost assignment block.
// ----------------------------------------------------------------------------
package sdpa_pkg;

    localparam int MAX_PRODUCTS_DEF = 8;
    localparam int MAX_DAYS_DEF     = 64;
    localparam int PRICE_BITS_DEF   = 16;

    localparam int PRODUCT_INDEX_W = 3;
    localparam int DAY_INDEX_W     = 6;
    localparam int UNIT_PRICE_W    = 16;
    localparam int TOTAL_W         = 19;

    localparam int PRODUCT_COUNT_W = 4;
    localparam int DAY_COUNT_W     = 7;
    localparam int CFG_DATA_W      = 7;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_PRODUCT_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DAY_COUNT     = 1'b1;

    localparam logic [PRODUCT_COUNT_W-1:0] PRODUCT_COUNT_RST = 4'd3;
    localparam logic [DAY_COUNT_W-1:0]     DAY_COUNT_RST     = 7'd3;

    // clamped run sizes: products up to 8, days up to 64
    localparam int PROD_N_W = 4;
    localparam int DAY_N_W  = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_ROW_RD,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN_RD,
        ST_FIN,
        ST_EMIT
    } sdpa_state_t;

    typedef struct packed {
        logic                go;
        logic [PROD_N_W-1:0] prod_n;
        logic [DAY_N_W-1:0]  day_n;
    } sdpa_start_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               feasible;
    } sdpa_result_t;

endpackage

// ----- rtl/core/sdpa_relax.sv -----
// ----------------------------------------------------------------------------
// sdpa_relax
// Shared add-compare-select unit: relaxes the running best cost of a subset
// with one candidate (previous-day cost of the subset minus one product plus
// that product's price today).
// ----------------------------------------------------------------------------
module sdpa_relax #(
    parameter int COST_W = sdpa_pkg::PRICE_BITS_DEF + 3
) (
    input  logic [COST_W:0]   best_in,   // {inf, cost}
    input  logic [COST_W:0]   rd_entry,  // {inf, cost} from row memory
    input  logic              rd_is_base,
    input  logic              rd_use,
    input  logic [COST_W-1:0] price_in,
    output logic [COST_W:0]   best_out
);

    logic [COST_W:0]   cur;
    logic [COST_W-1:0] sum;
    logic              take;

    always_comb
    begin
        cur  = rd_is_base ? rd_entry : best_in;
        sum  = rd_entry[COST_W-1:0] + price_in;
        take = rd_use && !rd_entry[COST_W] && !rd_is_base
               && (cur[COST_W] || (sum < cur[COST_W-1:0]));
        best_out = take ? {1'b0, sum} : cur;
    end

endmodule

// ----- rtl/core/sdpa_core.sv -----
// ----------------------------------------------------------------------------
// sdpa_core
// Price table, DP row memory and the sequencer that walks days, subsets and
// products through the shared relax unit.
// ----------------------------------------------------------------------------
module sdpa_core #(
    parameter int MAX_PRODUCTS = sdpa_pkg::MAX_PRODUCTS_DEF,
    parameter int MAX_DAYS     = sdpa_pkg::MAX_DAYS_DEF,
    parameter int PRICE_BITS   = sdpa_pkg::PRICE_BITS_DEF,
    localparam int PA_W        = (MAX_PRODUCTS * MAX_DAYS > 1)
                                 ? $clog2(MAX_PRODUCTS * MAX_DAYS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdpa_pkg::sdpa_start_t  start,
    input  logic                   price_we,
    input  logic [PA_W-1:0]        price_waddr,
    input  logic [PRICE_BITS-1:0]  price_wdata,
    output logic                   idle,
    output logic                   res_valid,
    input  logic                   res_ready,
    output sdpa_pkg::sdpa_result_t res
);

    localparam int SUB_W   = MAX_PRODUCTS;
    localparam int SUBSETS = 1 << MAX_PRODUCTS;
    localparam int X_W     = (MAX_PRODUCTS > 1) ? $clog2(MAX_PRODUCTS) : 1;
    localparam int NP_W    = $clog2(MAX_PRODUCTS + 1);
    localparam int D_W     = $clog2(MAX_DAYS + 1);
    localparam int COST_W  = PRICE_BITS + ((MAX_PRODUCTS > 1) ? $clog2(MAX_PRODUCTS) : 0);
    localparam int ENT_W   = COST_W + 1;

    function automatic logic [PA_W-1:0] paddr(input int p, input int d);
        return PA_W'(p * MAX_DAYS + d);
    endfunction

    sdpa_pkg::sdpa_state_t state_reg, state_next;

    logic [SUB_W-1:0] sub_reg,  sub_next;
    logic [SUB_W-1:0] full_reg, full_next;
    logic [X_W-1:0]   x_reg,    x_next;
    logic [D_W-1:0]   day_reg,  day_next;
    logic [NP_W-1:0]  np_reg,   np_next;
    logic [D_W-1:0]   nd_reg,   nd_next;
    logic             pend_base_reg, pend_base_next;
    logic             pend_use_reg,  pend_use_next;
    logic [ENT_W-1:0] best_reg, best_next;
    sdpa_pkg::sdpa_result_t res_reg, res_next;

    logic [PRICE_BITS-1:0] price_mem [MAX_PRODUCTS * MAX_DAYS];
    logic [PRICE_BITS-1:0] price_rdata;
    logic [PA_W-1:0]       price_raddr;

    logic [ENT_W-1:0] row_mem [SUBSETS];
    logic [ENT_W-1:0] row_rdata;
    logic [SUB_W-1:0] row_raddr;
    logic             row_we;
    logic [SUB_W-1:0] row_waddr;
    logic [ENT_W-1:0] row_wdata;

    localparam int TOTAL_PAD = sdpa_pkg::TOTAL_W;

    logic [ENT_W-1:0] relax_out;
    logic [X_W-1:0]   sub_enc;
    logic             sub_onehot;
    logic             last_x;
    logic             last_day;
    logic [COST_W+TOTAL_PAD-1:0] total_ext;

    // memories
    always_ff @(posedge clk)
    begin
        if (price_we)
        begin
            price_mem[price_waddr] <= price_wdata;
        end
        price_rdata <= price_mem[price_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rdata <= row_mem[row_raddr];
    end

    sdpa_relax #(
        .COST_W(COST_W)
    ) u_relax (
        .best_in   (best_reg),
        .rd_entry  (row_rdata),
        .rd_is_base(pend_base_reg),
        .rd_use    (pend_use_reg),
        .price_in  (COST_W'(price_rdata)),
        .best_out  (relax_out)
    );

    always_comb
    begin
        sub_enc = '0;
        for (int i = 0; i < MAX_PRODUCTS; i++)
        begin
            if (sub_reg[i])
            begin
                sub_enc = X_W'(i);
            end
        end
    end

    assign sub_onehot = (sub_reg != '0) && ((sub_reg & (sub_reg - 1'b1)) == '0);
    assign last_x     = (NP_W'(x_reg) == np_reg - 1'b1);
    assign last_day   = (day_reg == nd_reg - 1'b1);
    assign total_ext  = {{TOTAL_PAD{1'b0}}, row_rdata[COST_W-1:0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdpa_pkg::ST_IDLE:
            begin
                if (start.go)
                begin
                    if (start.day_n < sdpa_pkg::DAY_N_W'(start.prod_n))
                    begin
                        state_next = sdpa_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = sdpa_pkg::ST_INIT_RD;
                    end
                end
            end
            sdpa_pkg::ST_INIT_RD:
            begin
                state_next = sdpa_pkg::ST_INIT_WR;
            end
            sdpa_pkg::ST_INIT_WR:
            begin
                if (sub_reg != '0)
                begin
                    state_next = sdpa_pkg::ST_INIT_RD;
                end
                else if (nd_reg == D_W'(1))
                begin
                    state_next = sdpa_pkg::ST_FIN_RD;
                end
                else
                begin
                    state_next = sdpa_pkg::ST_ROW_RD;
                end
            end
            sdpa_pkg::ST_ROW_RD:
            begin
                state_next = sdpa_pkg::ST_SCAN;
            end
            sdpa_pkg::ST_SCAN:
            begin
                if (last_x)
                begin
                    state_next = sdpa_pkg::ST_DRAIN;
                end
            end
            sdpa_pkg::ST_DRAIN:
            begin
                if (sub_reg == SUB_W'(1) && last_day)
                begin
                    state_next = sdpa_pkg::ST_FIN_RD;
                end
                else
                begin
                    state_next = sdpa_pkg::ST_ROW_RD;
                end
            end
            sdpa_pkg::ST_FIN_RD:
            begin
                state_next = sdpa_pkg::ST_FIN;
            end
            sdpa_pkg::ST_FIN:
            begin
                state_next = sdpa_pkg::ST_EMIT;
            end
            sdpa_pkg::ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = sdpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdpa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        sub_next       = sub_reg;
        full_next      = full_reg;
        x_next         = x_reg;
        day_next       = day_reg;
        np_next        = np_reg;
        nd_next        = nd_reg;
        pend_base_next = 1'b0;
        pend_use_next  = 1'b0;
        best_next      = best_reg;
        res_next       = res_reg;
        price_raddr    = paddr(int'(x_reg), int'(day_reg));
        row_raddr      = sub_reg;
        row_we         = 1'b0;
        row_waddr      = sub_reg;
        row_wdata      = relax_out;
        idle           = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            sdpa_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (start.go)
                begin
                    np_next   = NP_W'(start.prod_n);
                    nd_next   = D_W'(start.day_n);
                    full_next = SUB_W'((1 << int'(start.prod_n)) - 1);
                    sub_next  = SUB_W'((1 << int'(start.prod_n)) - 1);
                    res_next  = '0;
                end
            end
            sdpa_pkg::ST_INIT_RD:
            begin
                price_raddr = paddr(int'(sub_enc), 0);
            end
            sdpa_pkg::ST_INIT_WR:
            begin
                row_we = 1'b1;
                if (sub_reg == '0)
                begin
                    row_wdata = '0;
                    day_next  = D_W'(1);
                    sub_next  = full_reg;
                end
                else
                begin
                    row_wdata = sub_onehot ? {1'b0, COST_W'(price_rdata)}
                                           : {1'b1, COST_W'(0)};
                    sub_next  = sub_reg - 1'b1;
                end
            end
            sdpa_pkg::ST_ROW_RD:
            begin
                row_raddr      = sub_reg;
                x_next         = '0;
                pend_base_next = 1'b1;
            end
            sdpa_pkg::ST_SCAN:
            begin
                best_next     = relax_out;
                row_raddr     = sub_reg ^ (SUB_W'(1) << x_reg);
                price_raddr   = paddr(int'(x_reg), int'(day_reg));
                pend_use_next = sub_reg[x_reg];
                x_next        = x_reg + 1'b1;
            end
            sdpa_pkg::ST_DRAIN:
            begin
                row_we    = 1'b1;
                row_wdata = relax_out;
                if (sub_reg == SUB_W'(1))
                begin
                    sub_next = full_reg;
                    day_next = day_reg + 1'b1;
                end
                else
                begin
                    sub_next = sub_reg - 1'b1;
                end
            end
            sdpa_pkg::ST_FIN_RD:
            begin
                row_raddr = full_reg;
            end
            sdpa_pkg::ST_FIN:
            begin
                res_next.feasible = 1'b1;
                res_next.total    = row_rdata[COST_W] ? '0
                                    : total_ext[sdpa_pkg::TOTAL_W-1:0];
            end
            sdpa_pkg::ST_EMIT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdpa_pkg::ST_IDLE;
            sub_reg       <= '0;
            full_reg      <= '0;
            x_reg         <= '0;
            day_reg       <= '0;
            np_reg        <= '0;
            nd_reg        <= '0;
            pend_base_reg <= 1'b0;
            pend_use_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            full_reg      <= full_next;
            x_reg         <= x_next;
            day_reg       <= day_next;
            np_reg        <= np_next;
            nd_reg        <= nd_next;
            pend_base_reg <= pend_base_next;
            pend_use_reg  <= pend_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sdpa_pkg::ST_SCAN |-> NP_W'(x_reg) < np_reg)
        else $error("product step beyond product count");

    a_row_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> row_waddr <= full_reg)
        else $error("row write above full subset");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start.go |-> state_reg == sdpa_pkg::ST_IDLE)
        else $error("start while busy");

    a_emit_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdpa_pkg::ST_EMIT && res_ready) |=> state_reg == sdpa_pkg::ST_IDLE)
        else $error("result transfer did not release sequencer");

    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sdpa_pkg::ST_DRAIN |-> $past(state_reg) == sdpa_pkg::ST_SCAN)
        else $error("row write without product scan");

endmodule

// ----- rtl/core/subset_dp_min_cost_assignment.sv -----
// ----------------------------------------------------------------------------
// subset_dp_min_cost_assignment
// Loads a product-by-day price table and, after the last price, runs the
// subset DP for the minimum cost of buying each product once, one per day.
// ----------------------------------------------------------------------------
// Throughput: one price transfer per cycle while the core is idle (no DP burst
//   running and no result held back by the output register).
// The DP run after the last price is paced by the single row memory read port
//   and the one shared add-compare unit; fewer days than products skip it.
// Reset: product_count and day_count return to 3; price table and DP row
//   are not cleared and need no clearing pass.
module subset_dp_min_cost_assignment #(
    parameter int MAX_PRODUCTS = sdpa_pkg::MAX_PRODUCTS_DEF,
    parameter int MAX_DAYS     = sdpa_pkg::MAX_DAYS_DEF,
    parameter int PRICE_BITS   = sdpa_pkg::PRICE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // product_index, day_index, unit_price
    input  logic                                s_tlast,  // last_price
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,  // min_total
    output logic                                m_tuser,  // feasible
    input  logic                                cfg_we,
    input  logic [sdpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sdpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int PA_W = (MAX_PRODUCTS * MAX_DAYS > 1)
                          ? $clog2(MAX_PRODUCTS * MAX_DAYS) : 1;

    logic [sdpa_pkg::PRODUCT_COUNT_W-1:0] product_count_reg, product_count_next;
    logic [sdpa_pkg::DAY_COUNT_W-1:0]     day_count_reg,     day_count_next;

    logic                   m_valid_reg, m_valid_next;
    sdpa_pkg::sdpa_result_t m_data_reg,  m_data_next;

    logic [sdpa_pkg::PRODUCT_INDEX_W-1:0] product_index;
    logic [sdpa_pkg::DAY_INDEX_W-1:0]     day_index;
    logic [sdpa_pkg::UNIT_PRICE_W-1:0]    unit_price;
    logic [PRICE_BITS+sdpa_pkg::UNIT_PRICE_W-1:0] price_ext;

    logic                   in_xfer;
    logic                   core_idle;
    logic                   res_valid;
    logic                   res_ready;
    sdpa_pkg::sdpa_result_t res;
    sdpa_pkg::sdpa_start_t  start;
    logic                   price_we;
    logic [PA_W-1:0]        price_waddr;
    int                     np_clamp;
    int                     nd_clamp;

    assign product_index = s_tdata[2:0];
    assign day_index     = s_tdata[8:3];
    assign unit_price    = s_tdata[24:9];
    assign price_ext     = {{PRICE_BITS{1'b0}}, unit_price};

    assign s_tready = core_idle;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        product_count_next = product_count_reg;
        day_count_next     = day_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sdpa_pkg::REG_PRODUCT_COUNT:
                begin
                    product_count_next = cfg_wdata[sdpa_pkg::PRODUCT_COUNT_W-1:0];
                end
                sdpa_pkg::REG_DAY_COUNT:
                begin
                    day_count_next = cfg_wdata;
                end
                default:
                begin
                    day_count_next = day_count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        np_clamp = int'(product_count_reg);
        if (np_clamp < 1)
        begin
            np_clamp = 1;
        end
        else if (np_clamp > MAX_PRODUCTS)
        begin
            np_clamp = MAX_PRODUCTS;
        end
        nd_clamp = int'(day_count_reg);
        if (nd_clamp < 1)
        begin
            nd_clamp = 1;
        end
        else if (nd_clamp > MAX_DAYS)
        begin
            nd_clamp = MAX_DAYS;
        end
    end

    assign start.go     = in_xfer && s_tlast;
    assign start.prod_n = sdpa_pkg::PROD_N_W'(np_clamp);
    assign start.day_n  = sdpa_pkg::DAY_N_W'(nd_clamp);

    assign price_we    = in_xfer && (int'(product_index) < MAX_PRODUCTS)
                         && (int'(day_index) < MAX_DAYS);
    assign price_waddr = PA_W'(int'(product_index) * MAX_DAYS + int'(day_index));

    sdpa_core #(
        .MAX_PRODUCTS(MAX_PRODUCTS),
        .MAX_DAYS    (MAX_DAYS),
        .PRICE_BITS  (PRICE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .price_we   (price_we),
        .price_waddr(price_waddr),
        .price_wdata(price_ext[PRICE_BITS-1:0]),
        .idle       (core_idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_count_reg <= sdpa_pkg::PRODUCT_COUNT_RST;
            day_count_reg     <= sdpa_pkg::DAY_COUNT_RST;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            product_count_reg <= product_count_next;
            day_count_reg     <= day_count_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg.total};
    assign m_tuser  = m_data_reg.feasible;

endmodule

// ----- test/tb_subset_dp_min_cost_assignment.sv -----
// ----------------------------------------------------------------------------
// tb_subset_dp_min_cost_assignment
// Loads price tables over the input stream under several product/day sizes,
// predicts each minimum-cost result with a subset DP of its own and checks
// every output transfer in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_subset_dp_min_cost_assignment;
    import sdpa_pkg::*;

    localparam int DAY_SLOTS   = MAX_DAYS_DEF;
    localparam int CELL_COUNT  = MAX_PRODUCTS_DEF * MAX_DAYS_DEF;
    localparam int STALL_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 20000;
    localparam int SETTLE      = 16;
    localparam longint NO_PLAN = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic {ROW_SIZES, ROW_PRICE} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [6:0]   pc_raw;
        logic [6:0]   dc_raw;
        logic [2:0]   product;
        logic [5:0]   day;
        logic [15:0]  price;
        logic         last;
        bit           typed;
        sdpa_result_t want;
    } dir_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // typed expectation traveling with the current input transfer
    bit           tag_typed  = 1'b0;
    sdpa_result_t tag_result = '0;

    logic [15:0]            price_mem [0:CELL_COUNT-1];
    logic [3:0]             products_reg = PRODUCT_COUNT_RST;
    logic [6:0]             days_reg     = DAY_COUNT_RST;
    sdpa_result_t           owed_q [$];
    sdpa_result_t           expected;
    sdpa_result_t           got;

    bit                     loaded [0:CELL_COUNT-1];
    int                     plan_np = 3;
    int                     plan_nd = 3;
    int                     items_sent = 0;
    int                     lasts_sent = 0;
    int                     tx_idle_pct = 19;
    int                     rx_idle_pct = 45;
    int                     hold_asked = 0;
    int                     hold_served = 0;
    int                     hold_left = 0;
    int                     stall_count = 0;
    int                     errors = 0;
    dir_row_t               dir_rows [$];

    subset_dp_min_cost_assignment u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int eff_products(input logic [3:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_PRODUCTS_DEF)
            return MAX_PRODUCTS_DEF;
        return int'(raw);
    endfunction

    function automatic int eff_days(input logic [6:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DAYS_DEF)
            return MAX_DAYS_DEF;
        return int'(raw);
    endfunction

    function automatic sdpa_result_t cheapest_plan(input int np, input int nd);
        longint       row [0:255];
        longint       cand;
        longint       sum;
        int           full;
        sdpa_result_t res;
        full = (1 << np) - 1;
        res  = '0;
        if (nd < np)
            return res;
        for (int s = 0; s <= full; s++)
            row[s] = NO_PLAN;
        row[0] = 0;
        for (int p = 0; p < np; p++)
            row[1 << p] = price_mem[p * DAY_SLOTS];
        for (int d = 1; d < nd; d++)
        begin
            // descending order keeps smaller sets at the previous day
            for (int s = full; s >= 1; s--)
            begin
                cand = row[s];
                for (int p = 0; p < np; p++)
                begin
                    if (s[p] && row[s ^ (1 << p)] != NO_PLAN)
                    begin
                        sum = row[s ^ (1 << p)] + price_mem[p * DAY_SLOTS + d];
                        if (sum < cand)
                            cand = sum;
                    end
                end
                row[s] = cand;
            end
        end
        cand = (row[full] == NO_PLAN) ? 0 : row[full];
        res.total    = cand[TOTAL_W-1:0];
        res.feasible = 1'b1;
        return res;
    endfunction

    function automatic logic [15:0] rand_price();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // prediction and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PRODUCT_COUNT)
                    products_reg = cfg_wdata[3:0];
                else if (cfg_index == REG_DAY_COUNT)
                    days_reg = cfg_wdata[6:0];
            end
            if (s_tvalid && s_tready)
            begin
                price_mem[{s_tdata[2:0], s_tdata[8:3]}] = s_tdata[24:9];
                if (s_tlast)
                begin
                    if (tag_typed)
                        expected = tag_result;
                    else
                        expected = cheapest_plan(eff_products(products_reg), eff_days(days_reg));
                    owed_q.push_back(expected);
                end
            end
            if (m_tvalid && m_tready)
            begin
                got.total    = m_tdata[TOTAL_W-1:0];
                got.feasible = m_tuser;
                if (owed_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual total %0d feasible %0b",
                             $time, got.total, got.feasible);
                end
                else
                begin
                    expected = owed_q.pop_front();
                    if (got.total !== expected.total)
                    begin
                        errors++;
                        $display("%0t min_total mismatch: expected %0d, actual %0d",
                                 $time, expected.total, got.total);
                    end
                    if (got.feasible !== expected.feasible)
                    begin
                        errors++;
                        $display("%0t feasible mismatch: expected %0b, actual %0b",
                                 $time, expected.feasible, got.feasible);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result receiver, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_price(input logic [2:0] prod, input logic [5:0] day,
                              input logic [15:0] price, input logic last,
                              input bit typed, input sdpa_result_t want);
        if (items_sent < 450)
        begin
            tx_idle_pct = 19;
            rx_idle_pct = 45;
        end
        else if (items_sent < 900)
        begin
            tx_idle_pct = 45;
            rx_idle_pct = 19;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {7'b0, price, day, prod};
        s_tlast    <= last;
        tag_typed  <= typed;
        tag_result <= want;
        loaded[{prod, day}] = 1'b1;
        items_sent++;
        if (last)
            lasts_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (owed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [6:0] pc_raw, input logic [6:0] dc_raw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PRODUCT_COUNT;
        cfg_wdata <= pc_raw;
        @(posedge clk);
        cfg_index <= REG_DAY_COUNT;
        cfg_wdata <= dc_raw;
        @(posedge clk);
        cfg_we  <= 1'b0;
        plan_np = eff_products(pc_raw[3:0]);
        plan_nd = eff_days(dc_raw);
    endtask

    // one table load ending in a last price; every cell the DP reads is loaded
    task automatic price_round(input bit set_sizes, input logic [6:0] pc_raw,
                               input logic [6:0] dc_raw);
        int         cells [$];
        int         pick;
        int         tmp;
        logic [8:0] c;
        if (set_sizes)
        begin
            settle_block();
            write_sizes(pc_raw, dc_raw);
        end
        if (plan_nd >= plan_np)
        begin
            for (int p = 0; p < plan_np; p++)
                for (int d = 0; d < plan_nd; d++)
                    if (!loaded[p * DAY_SLOTS + d])
                        cells.push_back(p * DAY_SLOTS + d);
            repeat ($urandom_range(0, plan_np * plan_nd))
                cells.push_back($urandom_range(0, plan_np - 1) * DAY_SLOTS
                                + $urandom_range(0, plan_nd - 1));
        end
        repeat ($urandom_range(0, 2))
            cells.push_back($urandom_range(0, CELL_COUNT - 1));
        if (cells.size() == 0)
            cells.push_back($urandom_range(0, CELL_COUNT - 1));
        for (int i = cells.size() - 1; i > 0; i--)
        begin
            pick        = $urandom_range(0, i);
            tmp         = cells[i];
            cells[i]    = cells[pick];
            cells[pick] = tmp;
        end
        for (int i = 0; i < cells.size(); i++)
        begin
            c = 9'(cells[i]);
            send_price(c[8:6], c[5:0], rand_price(), i == cells.size() - 1, 1'b0, '0);
        end
    endtask

    task automatic add_sizes(input logic [6:0] pc_raw, input logic [6:0] dc_raw);
        dir_row_t r;
        r        = '{kind: ROW_SIZES, default: '0};
        r.pc_raw = pc_raw;
        r.dc_raw = dc_raw;
        dir_rows.push_back(r);
    endtask

    task automatic add_price(input logic [2:0] prod, input logic [5:0] day,
                             input logic [15:0] price, input logic last, input bit typed,
                             input logic [TOTAL_W-1:0] total, input logic feasible);
        dir_row_t r;
        r            = '{kind: ROW_PRICE, default: '0};
        r.product    = prod;
        r.day        = day;
        r.price      = price;
        r.last       = last;
        r.typed      = typed;
        r.want.total    = total;
        r.want.feasible = feasible;
        dir_rows.push_back(r);
    endtask

    initial
    begin
        int         sel;
        int         np_n;
        int         nd_v;
        int         rounds;
        logic [6:0] pc_raw;

        for (int i = 0; i < CELL_COUNT; i++)
        begin
            price_mem[i] = '0;
            loaded[i]    = 1'b0;
        end

        // sizes after reset: 3 products, 3 days
        for (int p = 0; p < 3; p++)
            for (int d = 0; d < 3; d++)
                add_price(3'(p), 6'(d), 16'hFFFF, p == 2 && d == 2, p == 2 && d == 2,
                          19'd196605, 1'b1);
        add_price(3'd7, 6'd63, 16'h5A5A, 1'b0, 1'b0, '0, 1'b0);
        add_price(3'd0, 6'd0, 16'h0000, 1'b1, 1'b1, 19'd131070, 1'b1);
        add_price(3'd2, 6'd2, 16'h0000, 1'b1, 1'b1, 19'd65535, 1'b1);
        // too few days
        add_sizes(7'd4, 7'd3);
        add_price(3'd1, 6'd1, 16'h1234, 1'b1, 1'b1, 19'd0, 1'b0);
        add_sizes(7'd1, 7'd1);
        add_price(3'd0, 6'd0, 16'd1234, 1'b1, 1'b1, 19'd1234, 1'b1);
        // zero sizes clamp up to one
        add_sizes(7'd0, 7'd0);
        add_price(3'd0, 6'd0, 16'h0000, 1'b1, 1'b1, 19'd0, 1'b1);
        // oversized product count clamps to eight
        add_sizes(7'h7F, 7'd5);
        add_price(3'd3, 6'd4, 16'hA5A5, 1'b1, 1'b1, 19'd0, 1'b0);
        add_sizes(7'd2, 7'd2);
        add_price(3'd1, 6'd0, 16'hFFFF, 1'b0, 1'b0, '0, 1'b0);
        add_price(3'd1, 6'd1, 16'hFFFF, 1'b1, 1'b1, 19'd65535, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SIZES)
            begin
                settle_block();
                write_sizes(dir_rows[i].pc_raw, dir_rows[i].dc_raw);
            end
            else
                send_price(dir_rows[i].product, dir_rows[i].day, dir_rows[i].price,
                           dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end

        rounds = 0;
        while (items_sent < 850 || lasts_sent < 48)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                np_n = $urandom_range(1, 4);
                nd_v = $urandom_range(np_n, 8);
            end
            else if (sel == 6)
            begin
                np_n = $urandom_range(5, 6);
                nd_v = $urandom_range(np_n, 9);
            end
            else if (sel == 7)
            begin
                np_n = $urandom_range(2, 15);
                nd_v = $urandom_range(0, eff_products(4'(np_n)) - 1);
            end
            else if (sel == 8)
            begin
                np_n = 0;
                nd_v = $urandom_range(0, 6);
            end
            else
            begin
                np_n = $urandom_range(1, 3);
                nd_v = $urandom_range(20, 40);
            end
            pc_raw = {3'($urandom_range(0, 7)), 4'(np_n)};
            price_round(rounds == 0 || $urandom_range(0, 1) == 1, pc_raw, 7'(nd_v));
            if (rounds == 4)
            begin
                // receiver holds off while the next tables keep coming
                hold_asked++;
                price_round(1'b0, '0, '0);
                price_round(1'b0, '0, '0);
                price_round(1'b0, '0, '0);
            end
            rounds++;
        end

        // full-size table: every product, every day
        price_round(1'b1, 7'h7F, 7'h7F);

        settle_block();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sdpa_pkg.sv
rtl/core/sdpa_relax.sv
rtl/core/sdpa_core.sv
rtl/core/subset_dp_min_cost_assignment.sv
test/tb_subset_dp_min_cost_assignment.sv
